>>> design/psc_pkg.sv
package psc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OSS     = 3'd5;

    localparam logic [31:0] T_OFFSET   = 32'd4000;
    localparam logic [31:0] B4_BIAS    = 32'd32768;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] P_C1       = 32'd3038;
    localparam logic [31:0] P_C2       = 32'd7357;
    localparam logic [31:0] P_C3       = 32'd3791;
    localparam logic [17:0] P_MAX      = 18'h3FFFF;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

>>> design/psc_div.sv
module psc_div #(
    parameter int unsigned W_SIDE     = 1,
    parameter bit          SIGNED_DIV = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [31:0]       i_num,
    input  logic [31:0]       i_den,
    input  logic [W_SIDE-1:0] i_side,
    output logic              o_valid,
    output logic [31:0]       o_quo,
    output logic [W_SIDE-1:0] o_side
);
    import psc_pkg::*;

    localparam int unsigned N = DATA_W;

    logic              r_v    [N+1];
    logic [N-1:0]      r_rem  [N+1];
    logic [N-1:0]      r_quo  [N+1];
    logic [N-1:0]      r_den  [N+1];
    logic              r_neg  [N+1];
    logic [W_SIDE-1:0] r_side [N+1];
    logic              r_out_v;
    logic [N-1:0]      r_out_q;
    logic [W_SIDE-1:0] r_out_side;

    logic n_neg;
    logic [N-1:0] n_anum, n_aden;

    always_comb begin
        if (SIGNED_DIV) begin
            n_neg  = i_num[N-1] ^ i_den[N-1];
            n_anum = i_num[N-1] ? (~i_num + 1'b1) : i_num;
            n_aden = i_den[N-1] ? (~i_den + 1'b1) : i_den;
        end else begin
            n_neg  = 1'b0;
            n_anum = i_num;
            n_aden = i_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= '0;
            r_quo[0]  <= n_anum;
            r_den[0]  <= n_aden;
            r_neg[0]  <= n_neg;
            r_side[0] <= i_side;
        end
    end

    // One restoring quotient bit per stage.
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [N:0] n_sh, n_diff;
        always_comb begin
            n_sh   = {r_rem[k], r_quo[k][N-1]};
            n_diff = n_sh - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= n_diff[N] ? n_sh[N-1:0] : n_diff[N-1:0];
                r_quo[k+1]  <= {r_quo[k][N-2:0], ~n_diff[N]};
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[N];
        end
        if (i_en) begin
            r_out_q    <= r_neg[N] ? (~r_quo[N] + 1'b1) : r_quo[N];
            r_out_side <= r_side[N];
        end
    end

    assign o_valid = r_out_v;
    assign o_quo   = r_out_q;
    assign o_side  = r_out_side;

endmodule

>>> design/pressure_sensor_compensation.sv
// Barometric sensor compensation: each accepted word carries one raw temperature and one raw
// pressure reading and yields one word with temperature in 0.1 degC, pressure in Pa (saturated
// to 0..262143) and a divide error flag that forces both results to zero. The pipeline takes one
// word per cycle while the output is not stalled; the two 34-stage bit-per-stage dividers make
// up most of its registers. The whole pipeline holds while a finished result waits on the
// output. Calibration registers may be written only while no word is in flight.
module pressure_sensor_compensation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [15:0]                    i_raw_temperature,
    input  logic [15:0]                    i_raw_pressure,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [15:0]             o_temperature_tenths,
    output logic [17:0]                    o_pressure_pa,
    output logic                           o_divide_error,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [psc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import psc_pkg::*;

    logic [31:0] r_cal0, r_cal1, r_cal2, r_cal3, r_cal4;
    logic [1:0]  r_oss;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal0 <= '0;
            r_cal1 <= '0;
            r_cal2 <= '0;
            r_cal3 <= '0;
            r_cal4 <= '0;
            r_oss  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_AC1_AC2: r_cal0 <= i_cfg_data;
                CFG_AC3_AC4: r_cal1 <= i_cfg_data;
                CFG_AC5_AC6: r_cal2 <= i_cfg_data;
                CFG_B1_B2:   r_cal3 <= i_cfg_data;
                CFG_MC_MD:   r_cal4 <= i_cfg_data;
                CFG_OSS:     r_oss  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(r_cal0[31:16]);
    assign ac2 = sx16(r_cal0[15:0]);
    assign ac3 = sx16(r_cal1[31:16]);
    assign ac4 = {16'd0, r_cal1[15:0]};
    assign ac5 = {16'd0, r_cal2[31:16]};
    assign ac6 = {16'd0, r_cal2[15:0]};
    assign b1  = sx16(r_cal3[31:16]);
    assign b2  = sx16(r_cal3[15:0]);
    assign mc  = sx16(r_cal4[31:16]);
    assign md  = sx16(r_cal4[15:0]);

    logic en;
    logic r_out_v;
    assign en         = !r_out_v || i_out_ready;
    assign o_in_ready = en;

    // Stage 1 and 2: temperature front end.
    logic        r_s1_v, r_s2_v;
    logic [31:0] r_s1_m, r_s2_x1, r_s2_d;
    logic [15:0] r_s1_up, r_s2_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
        end
        if (en) begin
            r_s1_m  <= ({16'd0, i_raw_temperature} - ac6) * ac5;
            r_s1_up <= i_raw_pressure;
            r_s2_x1 <= asr(r_s1_m, 15);
            r_s2_d  <= asr(r_s1_m, 15) + md;
            r_s2_up <= r_s1_up;
        end
    end

    localparam int unsigned SIDE1_W = 32 + 16 + 1;
    logic               d1_v;
    logic [31:0]        d1_q;
    logic [SIDE1_W-1:0] d1_side;

    psc_div #(.W_SIDE(SIDE1_W), .SIGNED_DIV(1'b1)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_num   (mc << 11),
        .i_den   (r_s2_d),
        .i_side  ({r_s2_x1, r_s2_up, (r_s2_d == 32'd0)}),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_side  (d1_side)
    );

    // Stages 3 to 8: pressure coefficients.
    logic        r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v, r_s8_v;
    logic [31:0] r_s3_t, r_s3_b6;
    logic [15:0] r_s3_up, r_s4_up, r_s5_up, r_s6_up;
    logic        r_s3_e, r_s4_e, r_s5_e, r_s6_e, r_s7_e, r_s8_e;
    logic [31:0] r_s4_t, r_s5_t, r_s6_t, r_s7_t, r_s8_t;
    logic [31:0] r_s4_sq, r_s4_m2, r_s4_m3;
    logic [31:0] r_s5_mb2, r_s5_mb1, r_s5_x2a, r_s5_x1c;
    logic [31:0] r_s6_b3, r_s6_t2;
    logic [31:0] r_s7_b4, r_s7_b7b;
    logic [31:0] r_s8_b7, r_s8_b4;
    logic [31:0] b5, b6_x3, b3_n, x3c_n;

    assign b5 = d1_side[SIDE1_W-1 -: 32] + d1_q;
    assign b6_x3 = asr(r_s5_mb2, 11) + r_s5_x2a;
    assign b3_n = asr(((ac1 << 2) + b6_x3 << r_oss) + 32'd2, 2);
    assign x3c_n = asr(r_s5_x1c + asr(r_s5_mb1, 16) + 32'd2, 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= d1_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
            r_s8_v <= r_s7_v;
        end
        if (en) begin
            r_s3_t   <= asr(b5 + 32'd8, 4);
            r_s3_b6  <= b5 - T_OFFSET;
            r_s3_up  <= d1_side[16:1];
            r_s3_e   <= d1_side[0];

            r_s4_t   <= r_s3_t;
            r_s4_up  <= r_s3_up;
            r_s4_e   <= r_s3_e;
            r_s4_sq  <= r_s3_b6 * r_s3_b6;
            r_s4_m2  <= ac2 * r_s3_b6;
            r_s4_m3  <= ac3 * r_s3_b6;

            r_s5_t   <= r_s4_t;
            r_s5_up  <= r_s4_up;
            r_s5_e   <= r_s4_e;
            r_s5_mb2 <= b2 * asr(r_s4_sq, 12);
            r_s5_mb1 <= b1 * asr(r_s4_sq, 12);
            r_s5_x2a <= asr(r_s4_m2, 11);
            r_s5_x1c <= asr(r_s4_m3, 13);

            r_s6_t   <= r_s5_t;
            r_s6_up  <= r_s5_up;
            r_s6_e   <= r_s5_e;
            r_s6_b3  <= b3_n;
            r_s6_t2  <= x3c_n + B4_BIAS;

            r_s7_t   <= r_s6_t;
            r_s7_e   <= r_s6_e;
            r_s7_b4  <= (ac4 * r_s6_t2) >> 15;
            r_s7_b7b <= {16'd0, r_s6_up} - r_s6_b3;

            r_s8_t   <= r_s7_t;
            r_s8_e   <= r_s7_e;
            r_s8_b4  <= r_s7_b4;
            r_s8_b7  <= r_s7_b7b * (B7_SCALE >> r_oss);
        end
    end

    localparam int unsigned SIDE2_W = 32 + 2;
    logic               d2_v;
    logic [31:0]        d2_q;
    logic [SIDE2_W-1:0] d2_side;

    // A small b7 is doubled before dividing, a large one after.
    psc_div #(.W_SIDE(SIDE2_W), .SIGNED_DIV(1'b0)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s8_v),
        .i_num   (r_s8_b7[31] ? r_s8_b7 : (r_s8_b7 << 1)),
        .i_den   (r_s8_b4),
        .i_side  ({r_s8_t, r_s8_b7[31], r_s8_e || (r_s8_b4 == 32'd0)}),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_side  (d2_side)
    );

    // Stages 9 to 12: pressure correction and saturation.
    logic        r_s9_v, r_s10_v, r_s11_v;
    logic [31:0] r_s9_t, r_s10_t, r_s11_t;
    logic        r_s9_e, r_s10_e, r_s11_e;
    logic [31:0] r_s9_p, r_s10_p, r_s11_p;
    logic [31:0] r_s10_sqp, r_s10_m7, r_s11_m, r_s11_x2;
    logic [31:0] pf;
    logic signed [15:0] r_temp;
    logic [17:0] r_press;
    logic        r_err;

    assign pf = r_s11_p + asr(asr(r_s11_m, 16) + r_s11_x2 + P_C3, 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_v  <= 1'b0;
            r_s10_v <= 1'b0;
            r_s11_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s9_v  <= d2_v;
            r_s10_v <= r_s9_v;
            r_s11_v <= r_s10_v;
            r_out_v <= r_s11_v;
        end
        if (en) begin
            r_s9_t    <= d2_side[SIDE2_W-1 -: 32];
            r_s9_e    <= d2_side[0];
            r_s9_p    <= d2_side[1] ? (d2_q << 1) : d2_q;

            r_s10_t   <= r_s9_t;
            r_s10_e   <= r_s9_e;
            r_s10_p   <= r_s9_p;
            r_s10_sqp <= asr(r_s9_p, 8) * asr(r_s9_p, 8);
            r_s10_m7  <= P_C2 * r_s9_p;

            r_s11_t   <= r_s10_t;
            r_s11_e   <= r_s10_e;
            r_s11_p   <= r_s10_p;
            r_s11_m   <= r_s10_sqp * P_C1;
            r_s11_x2  <= asr(32'd0 - r_s10_m7, 16);

            r_err <= r_s11_e;
            if (r_s11_e) begin
                r_temp  <= '0;
                r_press <= '0;
            end else begin
                if ($signed(r_s11_t) > 32'sd32767) begin
                    r_temp <= 16'sh7FFF;
                end else if ($signed(r_s11_t) < -32'sd32768) begin
                    r_temp <= -16'sh8000;
                end else begin
                    r_temp <= r_s11_t[15:0];
                end
                if (pf[31]) begin
                    r_press <= '0;
                end else if (pf > {14'd0, P_MAX}) begin
                    r_press <= P_MAX;
                end else begin
                    r_press <= pf[17:0];
                end
            end
        end
    end

    assign o_out_valid          = r_out_v;
    assign o_temperature_tenths = r_temp;
    assign o_pressure_pa        = r_press;
    assign o_divide_error       = r_err;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_error |-> o_pressure_pa == 18'd0 && o_temperature_tenths == 16'sd0)
        else $error("divide error with nonzero result");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s11_p) && $stable(r_s11_v) && $stable(r_s3_t))
        else $error("pipeline moved during stall");
`endif

endmodule

>>> tb/sv/pressure_sensor_compensation_tb.sv
`timescale 1ns / 1ps

module pressure_sensor_compensation_tb;
    import psc_pkg::*;

    typedef struct packed {
        logic [15:0] ut;
        logic [15:0] up;
    } t_sample;

    typedef struct packed {
        logic [15:0] temp;
        logic [17:0] pres;
        logic        derr;
    } t_reading;

    localparam int PIPE_LAT = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_raw_temperature = '0;
    logic [15:0] i_raw_pressure = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [15:0] o_temperature_tenths;
    logic [17:0] o_pressure_pa;
    logic        o_divide_error;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    pressure_sensor_compensation i_dut (.*);

    always #2 i_clk = ~i_clk;

    logic [31:0] cal_regs [5];
    logic [1:0]  oss_reg;

    t_sample  pending_samples [$];
    t_reading expected_readings [$];
    int       error_count = 0;
    int       samples_sent = 0;
    int       readings_seen = 0;
    int       div_errors_seen = 0;
    bit       sender_idle_en = 1'b0;
    bit       receiver_idle_en = 1'b0;
    int       receiver_hold = 0;

    function automatic logic [31:0] sra32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_reading compensate(t_sample s);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, t, d, sq;
        logic signed [31:0] ts, ps;
        t_reading r;
        r = '0;
        ac1 = sext16(cal_regs[0][31:16]); ac2 = sext16(cal_regs[0][15:0]);
        ac3 = sext16(cal_regs[1][31:16]); ac4 = {16'd0, cal_regs[1][15:0]};
        ac5 = {16'd0, cal_regs[2][31:16]}; ac6 = {16'd0, cal_regs[2][15:0]};
        b1 = sext16(cal_regs[3][31:16]); b2 = sext16(cal_regs[3][15:0]);
        mc = sext16(cal_regs[4][31:16]); md = sext16(cal_regs[4][15:0]);
        ut = {16'd0, s.ut};
        up = {16'd0, s.up};
        x1 = sra32((ut - ac6) * ac5, 15);
        d = x1 + md;
        if (d == 0) begin
            r.derr = 1'b1;
            return r;
        end
        // Truncating signed divide; the only overflow case wraps to the dividend.
        if (d == 32'hFFFF_FFFF) x2 = -(mc << 11);
        else x2 = $signed(mc << 11) / $signed(d);
        b5 = x1 + x2;
        t = sra32(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        sq = sra32(b6 * b6, 12);
        x1 = sra32(b2 * sq, 11);
        x2 = sra32(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sra32(((ac1 * 32'd4 + x3) << oss_reg) + 32'd2, 2);
        x1 = sra32(ac3 * b6, 13);
        x2 = sra32(b1 * sq, 16);
        x3 = sra32(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) begin
            r.derr = 1'b1;
            return r;
        end
        b7 = (up - b3) * (32'd50000 >> oss_reg);
        if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = sra32(p, 8) * sra32(p, 8);
        x1 = sra32(x1 * 32'd3038, 16);
        x2 = sra32(32'd0 - 32'd7357 * p, 16);
        p = p + sra32(x1 + x2 + 32'd3791, 4);
        ts = t;
        if (ts > 32767) ts = 32767;
        if (ts < -32768) ts = -32768;
        ps = p;
        if (ps < 0) ps = 0;
        if (ps > 262143) ps = 262143;
        r.temp = ts[15:0];
        r.pres = ps[17:0];
        return r;
    endfunction

    // The driver keeps valid high and the word steady until the handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_readings.push_back(compensate({i_raw_temperature, i_raw_pressure}));
                samples_sent++;
            end
            if ((!i_in_valid || o_in_ready) && pending_samples.size() > 0
                    && !(sender_idle_en && $urandom_range(99) < 16)) begin
                i_in_valid <= 1'b1;
                {i_raw_temperature, i_raw_pressure} <= pending_samples.pop_front();
            end else if (i_in_valid && o_in_ready) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (receiver_hold > 0) begin
                receiver_hold <= receiver_hold - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(receiver_idle_en && $urandom_range(99) < 16);
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            readings_seen++;
            if (o_divide_error) div_errors_seen++;
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected word temp=%0d pres=%0d err=%0b", $time,
                         o_temperature_tenths, o_pressure_pa, o_divide_error);
                error_count++;
            end else begin
                want = expected_readings.pop_front();
                if (o_temperature_tenths !== want.temp) begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             $signed(want.temp), o_temperature_tenths);
                    error_count++;
                end
                if (o_pressure_pa !== want.pres) begin
                    $display("%0t: pressure expected %0d actual %0d", $time,
                             want.pres, o_pressure_pa);
                    error_count++;
                end
                if (o_divide_error !== want.derr) begin
                    $display("%0t: divide error expected %0b actual %0b", $time,
                             want.derr, o_divide_error);
                    error_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < 5) cal_regs[idx] = data;
        else if (idx == CFG_OSS) oss_reg = data[1:0];
    endtask

    // Checked between edges so that queue and valid updates of one edge are all seen.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_samples.size() != 0 || i_in_valid
                   || expected_readings.size() != 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [31:0] c0, c1, c2, c3, c4, input logic [1:0] oss);
        write_reg(CFG_AC1_AC2, c0);
        write_reg(CFG_AC3_AC4, c1);
        write_reg(CFG_AC5_AC6, c2);
        write_reg(CFG_B1_B2, c3);
        write_reg(CFG_MC_MD, c4);
        write_reg(CFG_OSS, {30'd0, oss});
    endtask

    // A typical sensor calibration, used as the base for plausible random sets.
    localparam logic [31:0] TYP0 = {16'd408, -16'sd72};
    localparam logic [31:0] TYP1 = {-16'sd14383, 16'd32741};
    localparam logic [31:0] TYP2 = {16'd32757, 16'd23153};
    localparam logic [31:0] TYP3 = {16'd6190, 16'd4};
    localparam logic [31:0] TYP4 = {-16'sd8711, 16'd2868};

    function automatic logic [31:0] jitter(logic [31:0] base);
        return {base[31:16] + 16'($urandom_range(64)) - 16'd32,
                base[15:0] + 16'($urandom_range(64)) - 16'd32};
    endfunction

    task automatic push_random(input int n, input bit plausible);
        t_sample s;
        repeat (n) begin
            if (plausible && $urandom_range(3) != 0) begin
                s.ut = 16'($urandom_range(22000, 32000));
                s.up = 16'($urandom_range(16000, 40000));
            end else begin
                s.ut = 16'($urandom);
                s.up = 16'($urandom);
            end
            pending_samples.push_back(s);
        end
    endtask

    initial begin
        foreach (cal_regs[k]) cal_regs[k] = '0;
        oss_reg = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: zero divisor on the temperature path.
        pending_samples.push_back('{16'd0, 16'd0});
        pending_samples.push_back('{16'hFFFF, 16'hFFFF});
        drain();

        // Typical set: extremes of both fields and mid values.
        load_cal(TYP0, TYP1, TYP2, TYP3, TYP4, 2'd0);
        pending_samples.push_back('{16'd27898, 16'd23843});
        pending_samples.push_back('{16'd0, 16'd0});
        pending_samples.push_back('{16'hFFFF, 16'hFFFF});
        pending_samples.push_back('{16'h0000, 16'hFFFF});
        pending_samples.push_back('{16'hFFFF, 16'h0000});
        pending_samples.push_back('{16'h5555, 16'hAAAA});
        pending_samples.push_back('{16'hAAAA, 16'h5555});
        drain();

        // Maximum oversampling; also a set where ac4 is zero so b4 is zero.
        load_cal(TYP0, TYP1, TYP2, TYP3, TYP4, 2'd3);
        pending_samples.push_back('{16'd27898, 16'd23843});
        pending_samples.push_back('{16'd27898, 16'd0});
        drain();
        write_reg(CFG_AC3_AC4, {TYP1[31:16], 16'd0});
        pending_samples.push_back('{16'd27898, 16'd23843});
        drain();
        // x1 is zero because ac5 is zero, and md is zero: temperature divisor zero.
        load_cal(32'h8000_7FFF, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h7FFF_8000,
                 32'h7FFF_0000, 2'd1);
        pending_samples.push_back('{16'd100, 16'd100});
        drain();
        // Extreme coefficients drive saturation and the large b7 branch.
        load_cal(32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h8000_7FFF,
                 32'h8000_7FFF, 2'd2);
        pending_samples.push_back('{16'hFFFF, 16'd0});
        pending_samples.push_back('{16'd0, 16'hFFFF});
        pending_samples.push_back('{16'h8000, 16'h8000});
        pending_samples.push_back('{16'h7FFF, 16'h7FFF});
        drain();
        load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 2'd3);
        pending_samples.push_back('{16'h1234, 16'hFEDC});
        pending_samples.push_back('{16'hFFFF, 16'hFFFF});
        drain();

        // Random phases, mostly near a real calibration.
        sender_idle_en = 1'b1;
        receiver_idle_en = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5)
                load_cal($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
            else
                load_cal(jitter(TYP0), jitter(TYP1), jitter(TYP2), jitter(TYP3),
                         jitter(TYP4), 2'(ph));
            if (ph == 2) begin
                // Hold the output long enough for the pipeline to fill and stall.
                sender_idle_en = 1'b0;
                receiver_hold = 300;
            end
            push_random(110, ph != 5);
            drain();
            sender_idle_en = 1'b1;
        end
        // A stretch without any idling.
        sender_idle_en = 1'b0;
        receiver_idle_en = 1'b0;
        load_cal(jitter(TYP0), jitter(TYP1), jitter(TYP2), jitter(TYP3), jitter(TYP4), 2'd1);
        push_random(60, 1'b1);
        drain();

        $display("Checked %0d readings from %0d samples, %0d with divide errors,",
                 readings_seen, samples_sent, div_errors_seen);
        $display("over oversampling 0..3 and extreme, typical and random calibration.");
        if (error_count == 0 && expected_readings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
